// ----- rtl/p2g2_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// p2g2_pkg: shared definitions for the 2-bit grayscale packer
// Pixel format codes, register indexes, opcodes and the gray weighting.
// ----------------------------------------------------------------------------
package p2g2_pkg;

  typedef logic [2:0]  pixel_fmt_t;
  typedef logic [1:0]  reg_index_t;
  typedef logic [23:0] pal_entry_t;

  localparam pixel_fmt_t FMT_2BIT   = 3'd0;
  localparam pixel_fmt_t FMT_4BIT   = 3'd1;
  localparam pixel_fmt_t FMT_8BIT   = 3'd2;
  localparam pixel_fmt_t FMT_RGB565 = 3'd3;
  localparam pixel_fmt_t FMT_RGB24  = 3'd4;
  localparam pixel_fmt_t FMT_RGBA32 = 3'd5;

  localparam reg_index_t REG_PIXEL_FORMAT = 2'd0;
  localparam reg_index_t REG_USE_PALETTE  = 2'd1;
  localparam reg_index_t REG_IMAGE_WIDTH  = 2'd2;
  localparam reg_index_t REG_IMAGE_HEIGHT = 2'd3;

  localparam logic OP_IMAGE   = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  localparam int CFG_DATA_W   = 12;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int ROW_W        = 11;

  // Top two bits of (r + 2g + b) / 4.
  function automatic logic [1:0] gray_top2(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    logic [9:0] sum;
    sum = {2'b00, r} + {1'b0, g, 1'b0} + {2'b00, b};
    return sum[9:8];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pixel_to_gray2_packer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_to_gray2_packer_unit: source pixels to packed 2-bit grayscale
// Assembles pixels of the configured format, converts each to gray and
// packs the top two gray bits four to an output byte, first pixel on top.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one word per cycle. With tuser low, tdata[7:0]
//   is a source image byte; with tuser high, the word writes one palette
//   entry (index and red, green, blue). Palette writes produce no output.
//   The master stream delivers packed gray bytes; tlast marks the last byte
//   of a row and tuser marks the last byte of the image.
//   The configuration channel sets format, palette use, width and height;
//   it is to be written by the user only while the stream is idle; the block
//   does not enforce this. It is always ready out of reset. A source image
//   word passes one palette read register, then one result register.
//   Throughput: one source word per cycle unless the master side stalls,
//   set by the single-pass pixel logic between the two registers.
//   A stalled master side holds its word; the block keeps taking one more
//   source word and then holds tready low until the result moves on.
//   Reset clears the packing state, row and column counts and resets the
//   configuration; palette contents are not cleared and must be loaded.
module pixel_to_gray2_packer_unit
  import p2g2_pkg::*;
#(
  parameter int MAX_WIDTH     = 2048,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: data_byte, palette_index, palette_red, palette_green, palette_blue
  input  logic [39:0]           s_tdata,
  // tuser: opcode
  input  logic                  s_tuser,
  // master stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata: gray_byte
  output logic [7:0]            m_tdata,
  output logic                  m_tlast,
  // tuser: last_of_image
  output logic                  m_tuser,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PAW  = $clog2(PALETTE_DEPTH);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

  // Configuration registers
  pixel_fmt_t            pixel_format;
  logic                  use_palette;
  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_8BIT;
      use_palette  <= 1'b0;
      image_width  <= CFG_DATA_W'(1);
      image_height <= CFG_DATA_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[2:0];
        REG_USE_PALETTE:  use_palette  <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default:          pixel_format <= pixel_format;
      endcase
    end
  end

  // Effective width and height with zero and oversize clamped.
  logic [CMPW-1:0]       eff_w;
  logic [CFG_DATA_W-1:0] eff_h;

  always_comb begin
    if (image_width == '0) begin
      eff_w = CMPW'(1);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      eff_w = CMPW'(MAX_WIDTH);
    end else begin
      eff_w = CMPW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = CFG_DATA_W'(1);
    end else if (image_height > CFG_DATA_W'(HEIGHT_LIMIT)) begin
      eff_h = CFG_DATA_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = image_height;
    end
  end

  // Input handshake and the first register stage
  logic s1_valid;
  logic s1_adv;
  logic s1_fire;
  logic s_fire;

  assign s1_adv   = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && s1_adv;
  assign s_tready = !rst && (!s1_valid || s1_adv);
  assign s_fire   = s_tvalid && s_tready;

  // Palette: two copies serve the first two pixels of a word. The last two
  // pixels only occur with 2-bit indexes, so they read a register copy of
  // the four lowest entries.
  logic [7:0]     rd_idx  [4];
  logic [PAW-1:0] rd_addr [2];
  logic           rd_oob  [4];
  logic [7:0]     wr_idx;
  pal_entry_t     wr_entry;
  logic           wr_ok;

  pal_entry_t pal_mem [2][PALETTE_DEPTH];
  pal_entry_t pal_low [4];
  pal_entry_t pal_rd  [4];
  logic       pal_oob [4];
  logic [7:0] s1_data;

  assign wr_idx   = s_tdata[15:8];
  assign wr_entry = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
  assign wr_ok    = {1'b0, wr_idx} < 9'(PALETTE_DEPTH);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rd_idx[c] = 8'd0;
    end
    case (pixel_format)
      FMT_2BIT: begin
        for (int c = 0; c < 4; c++) begin
          rd_idx[c] = {6'd0, s_tdata[7-2*c -: 2]};
        end
      end
      FMT_4BIT: begin
        rd_idx[0] = {4'd0, s_tdata[7:4]};
        rd_idx[1] = {4'd0, s_tdata[3:0]};
      end
      default: rd_idx[0] = s_tdata[7:0];
    endcase
    for (int c = 0; c < 4; c++) begin
      rd_oob[c] = {1'b0, rd_idx[c]} >= 9'(PALETTE_DEPTH);
    end
    for (int c = 0; c < 2; c++) begin
      rd_addr[c] = rd_idx[c][PAW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_tuser == OP_PALETTE && wr_ok) begin
      for (int c = 0; c < 2; c++) begin
        pal_mem[c][wr_idx[PAW-1:0]] <= wr_entry;
      end
      if (wr_idx[7:2] == 6'd0) begin
        pal_low[wr_idx[1:0]] <= wr_entry;
      end
    end
    if (s_fire && s_tuser == OP_IMAGE) begin
      for (int c = 0; c < 2; c++) begin
        pal_rd[c] <= pal_mem[c][rd_addr[c]];
      end
      for (int c = 2; c < 4; c++) begin
        pal_rd[c] <= pal_low[rd_idx[c][1:0]];
      end
      for (int c = 0; c < 4; c++) begin
        pal_oob[c] <= rd_oob[c];
      end
      s1_data <= s_tdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire && s_tuser == OP_IMAGE) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Packing state
  logic [7:0]       acc;
  logic [3:0]       bits_left;
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [23:0]      gather;
  logic [1:0]       bip;

  logic [7:0]       acc_next;
  logic [3:0]       bits_left_next;
  logic [CW-1:0]    col_next;
  logic [ROW_W-1:0] row_next;
  logic [23:0]      gather_next;
  logic [1:0]       bip_next;

  // Pixel assembly
  logic             sub_byte;
  logic [1:0]       pix_top [4];
  logic [2:0]       npix;
  logic [2:0]       nbytes;
  logic [23:0]      gather_new;
  logic [7:0]       pr, pg, pb;
  logic             px_done;

  always_comb begin
    sub_byte = !(pixel_format inside {FMT_RGB565, FMT_RGB24, FMT_RGBA32});
    for (int k = 0; k < 4; k++) begin
      pix_top[k] = 2'd0;
    end
    npix        = 3'd0;
    nbytes      = 3'd4;
    gather_new  = gather;
    pr          = 8'd0;
    pg          = 8'd0;
    pb          = 8'd0;
    px_done     = 1'b0;
    bip_next    = 2'd0;
    gather_next = 24'd0;

    if (sub_byte) begin
      case (pixel_format)
        FMT_2BIT: begin
          npix = 3'd4;
          for (int k = 0; k < 4; k++) begin
            pix_top[k] = s1_data[7-2*k -: 2];
          end
        end
        FMT_4BIT: begin
          npix       = 3'd2;
          pix_top[0] = s1_data[7:6];
          pix_top[1] = s1_data[3:2];
        end
        default: begin
          npix       = 3'd1;
          pix_top[0] = s1_data[7:6];
        end
      endcase
      if (use_palette) begin
        for (int k = 0; k < 4; k++) begin
          pix_top[k] = pal_oob[k] ? 2'd0 :
                       gray_top2(pal_rd[k][23:16], pal_rd[k][15:8], pal_rd[k][7:0]);
        end
      end
    end else begin
      case (pixel_format)
        FMT_RGB565: nbytes = 3'd2;
        FMT_RGB24:  nbytes = 3'd3;
        default:    nbytes = 3'd4;
      endcase
      case (bip)
        2'd0:    gather_new[7:0]   = s1_data;
        2'd1:    gather_new[15:8]  = s1_data;
        2'd2:    gather_new[23:16] = s1_data;
        default: gather_new        = gather;
      endcase
      px_done = ({1'b0, bip} + 3'd1) >= nbytes;
      if (px_done) begin
        npix = 3'd1;
        if (pixel_format == FMT_RGB565) begin
          pr = {gather_new[15:11], 3'd0};
          pg = {gather_new[10:5], 2'd0};
          pb = {gather_new[4:0], 3'd0};
        end else begin
          pr = gather_new[7:0];
          pg = gather_new[15:8];
          pb = gather_new[23:16];
        end
        pix_top[0] = gray_top2(pr, pg, pb);
      end else begin
        bip_next    = bip + 2'd1;
        gather_next = gather_new;
      end
    end
  end

  // Pixel packing: up to four pixels, stopping at the first output byte.
  logic             emit;
  logic [7:0]       out_byte;
  logic             out_row;
  logic             out_img;
  logic [CW:0]      col_inc;
  logic [CFG_DATA_W-1:0] row_inc;
  logic             row_end;

  always_comb begin
    acc_next       = acc;
    bits_left_next = bits_left;
    col_next       = col;
    row_next       = row;
    emit           = 1'b0;
    out_byte       = 8'd0;
    out_row        = 1'b0;
    out_img        = 1'b0;
    col_inc        = '0;
    row_inc        = '0;
    row_end        = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < npix && !emit) begin
        acc_next       = {acc_next[5:0], pix_top[k]};
        bits_left_next = (bits_left_next >= 4'd2) ? bits_left_next - 4'd2 : 4'd0;
        col_inc        = {1'b0, col_next} + (CW+1)'(1);
        row_end        = CMPW'(col_inc) >= eff_w;
        row_inc        = {1'b0, row_next} + CFG_DATA_W'(1);
        if (bits_left_next == 4'd0 || row_end) begin
          emit           = 1'b1;
          out_byte       = 8'(acc_next << bits_left_next[2:0]);
          out_row        = row_end;
          out_img        = row_end && (row_inc >= eff_h);
          acc_next       = 8'd0;
          bits_left_next = 4'd8;
        end
        if (row_end) begin
          col_next = '0;
          row_next = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
        end else begin
          col_next = col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 8'd0;
      bits_left <= 4'd8;
      col       <= '0;
      row       <= '0;
      gather    <= 24'd0;
      bip       <= 2'd0;
    end else if (s1_fire) begin
      acc       <= acc_next;
      bits_left <= bits_left_next;
      col       <= col_next;
      row       <= row_next;
      // A row end always starts the next pixel afresh.
      gather    <= row_end && emit ? 24'd0 : gather_next;
      bip       <= row_end && emit ? 2'd0 : bip_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      m_tdata <= out_byte;
      m_tlast <= out_row;
      m_tuser <= out_img;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/p2g2_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// p2g2_checker: port-level checks for the 2-bit grayscale packer
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module p2g2_checker
  import p2g2_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // A stalled output word holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output word changed while stalled");

  // The end of the image is always also the end of a row.
  a_img_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("image end without row end");

  // A fresh output word must come from a source image word taken at the input.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == OP_IMAGE), 2))
    else $error("output word without a source image word");

  // Reset leaves no output word pending.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind pixel_to_gray2_packer_unit p2g2_checker u_p2g2_checker (.*);
`default_nettype wire

// ----- test/pixel_to_gray2_packer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// pixel_to_gray2_packer_unit_tb: self-checking bench for the 2-bit gray packer
// Feeds palette loads and source image bytes in every pixel format and checks
// each packed gray byte and its row and image end flags against a cycle-free
// model of the packer, or a given word in the short directed table that comes
// first; then random settings and words with random stalls on both streams.
// ----------------------------------------------------------------------------
module pixel_to_gray2_packer_unit_tb;
  import p2g2_pkg::*;

  localparam int MAX_ROW     = 2048;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] gray;
    logic       row_end;
    logic       img_end;
  } gray_word_t;

  typedef struct packed {
    bit          is_cfg;
    logic        op;
    logic [39:0] word;
    pixel_fmt_t  fmt;
    logic        pal;
    logic [11:0] w;
    logic [11:0] h;
    bit          typed;
    gray_word_t  want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [39:0]           s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_to_gray2_packer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  gray_word_t gray_due[$];
  plan_row_t  plan[$];
  int         errors = 0;
  int         quiet = 0;
  bit         no_gaps = 1'b0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  // Shadow of the packer state and its settings.
  pal_entry_t  shade_pal [256];
  logic [7:0]  pack_acc;
  int          pack_room;
  int          col_pos;
  int          row_pos;
  logic [23:0] gather_bytes;
  int          gather_cnt;
  pixel_fmt_t  fmt_reg;
  logic        pal_reg;
  logic [11:0] width_reg;
  logic [11:0] height_reg;

  function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    int sum;
    sum = int'(r) + 2 * int'(g) + int'(b);
    return 8'(sum >> 2);
  endfunction

  function automatic logic [7:0] pal_luma(input logic [7:0] idx);
    pal_entry_t e;
    e = shade_pal[idx];
    return luma(e[23:16], e[15:8], e[7:0]);
  endfunction

  // Shifts one pixel into the packing byte; returns 1 on a full byte or row end.
  function automatic bit add_pixel(input logic [7:0] g8, output gray_word_t res);
    int w;
    int h;
    bit row_end;
    bit emit;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_ROW) ? MAX_ROW : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg);
    res = '0;
    pack_acc = {pack_acc[5:0], g8[7:6]};
    pack_room = (pack_room >= 2) ? pack_room - 2 : 0;
    col_pos++;
    row_end = (col_pos >= w);
    emit = (pack_room == 0) || row_end;
    if (emit) begin
      res.gray = pack_acc << pack_room;
      res.row_end = row_end;
      res.img_end = row_end && (row_pos + 1 >= h);
      pack_acc = '0;
      pack_room = 8;
    end
    if (row_end) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
      gather_cnt = 0;
      gather_bytes = '0;
    end
    return emit;
  endfunction

  function automatic bit predict_gray(input logic op, input logic [39:0] word,
                                      output gray_word_t res);
    logic [7:0] d;
    logic [7:0] px;
    logic [7:0] g;
    logic [7:0] g0;
    logic [7:0] g1;
    logic [7:0] g2;
    int npix;
    int nbytes;
    res = '0;
    d = word[7:0];
    if (op == OP_PALETTE) begin
      shade_pal[word[15:8]] = {word[23:16], word[31:24], word[39:32]};
      return 0;
    end
    // Sub-byte and byte formats, the two unused codes included.
    if (fmt_reg <= FMT_8BIT || fmt_reg > FMT_RGBA32) begin
      gather_cnt = 0;
      gather_bytes = '0;
      npix = (fmt_reg == FMT_2BIT) ? 4 : (fmt_reg == FMT_4BIT) ? 2 : 1;
      for (int k = 0; k < npix; k++) begin
        if (npix == 4) begin
          px = (d >> (6 - 2 * k)) & 8'h03;
          g = pal_reg ? pal_luma(px) : px << 6;
        end else if (npix == 2) begin
          px = (d >> (4 - 4 * k)) & 8'h0f;
          g = pal_reg ? pal_luma(px) : {px[3:0], px[3:0]};
        end else begin
          g = pal_reg ? pal_luma(d) : d;
        end
        // A finished byte drops whatever pixels are left in this source byte.
        if (add_pixel(g, res)) return 1;
      end
      return 0;
    end
    nbytes = (fmt_reg == FMT_RGB565) ? 2 : (fmt_reg == FMT_RGB24) ? 3 : 4;
    if (gather_cnt < 3) gather_bytes[8 * gather_cnt +: 8] = d;
    if (gather_cnt + 1 < nbytes) begin
      gather_cnt = (gather_cnt + 1) & 3;
      return 0;
    end
    gather_cnt = 0;
    g0 = gather_bytes[7:0];
    g1 = gather_bytes[15:8];
    g2 = gather_bytes[23:16];
    gather_bytes = '0;
    if (nbytes == 2)
      return add_pixel(luma({g1[7:3], 3'b000}, {g1[2:0], g0[7:5], 2'b00},
                            {g0[4:0], 3'b000}), res);
    return add_pixel(luma(g0, g1, g2), res);
  endfunction

  function automatic plan_row_t cfg_row(input pixel_fmt_t fmt, input logic pal,
                                        input logic [11:0] w, input logic [11:0] h);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.fmt = fmt;
    r.pal = pal;
    r.w = w;
    r.h = h;
    return r;
  endfunction

  function automatic plan_row_t word_row(input logic op, input logic [39:0] word,
                                         input bit typed = 1'b0,
                                         input gray_word_t want = '0);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.word = word;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic logic [11:0] pick_size(input int typical);
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 12'($urandom_range(typical, 1));
    if (roll < 85) return 12'($urandom_range(64));
    return 12'($urandom_range(4095));
  endfunction

  // Lets the block drain so that a register write finds it idle.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (gray_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input pixel_fmt_t fmt, input logic pal,
                               input logic [11:0] w, input logic [11:0] h);
    reg_index_t idx;
    logic [11:0] val;
    settle();
    for (int i = 0; i < 4; i++) begin
      idx = reg_index_t'(i);
      // Unused high bits of the narrow registers carry noise.
      case (idx)
        REG_PIXEL_FORMAT: val = {9'($urandom), fmt};
        REG_USE_PALETTE:  val = {11'($urandom), pal};
        REG_IMAGE_WIDTH:  val = w;
        default:          val = h;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    fmt_reg = fmt;
    pal_reg = pal;
    width_reg = w;
    height_reg = h;
  endtask

  task automatic send_word(input logic op, input logic [39:0] word,
                           input bit typed = 1'b0, input gray_word_t want = '0);
    gray_word_t got;
    bit made;
    if (!no_gaps && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 25);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
    made = predict_gray(op, word, got);
    if (typed) gray_due.push_back(want);
    else if (made) gray_due.push_back(got);
  endtask

  // Result side: random backpressure plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= no_gaps || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    gray_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (gray_due.size() == 0) begin
        $display("%0t: unexpected gray word: got %h last %b image %b",
                 $time, m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        want = gray_due.pop_front();
        if (m_tdata !== want.gray) begin
          $display("%0t: gray byte: expected %h, got %h", $time, want.gray, m_tdata);
          errors++;
        end
        if (m_tlast !== want.row_end) begin
          $display("%0t: row end: expected %b, got %b", $time, want.row_end, m_tlast);
          errors++;
        end
        if (m_tuser !== want.img_end) begin
          $display("%0t: image end: expected %b, got %b", $time, want.img_end, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet);
      $display("pixel_to_gray2_packer_unit regression: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] rnd;
    int          sent;
    int          span;
    int          phase_no;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_IMAGE;
    cfg_valid = 1'b0;
    cfg_index = REG_PIXEL_FORMAT;
    cfg_data = '0;
    pack_acc = '0;
    pack_room = 8;
    col_pos = 0;
    row_pos = 0;
    gather_bytes = '0;
    gather_cnt = 0;
    fmt_reg = FMT_8BIT;
    pal_reg = 1'b0;
    width_reg = 12'd1;
    height_reg = 12'd1;

    // Reset settings: 8-bit gray, one pixel per row, one row per image.
    plan.push_back(word_row(OP_IMAGE, 40'hff, 1'b1, {8'hc0, 1'b1, 1'b1}));
    plan.push_back(word_row(OP_IMAGE, 40'h00, 1'b1, {8'h00, 1'b1, 1'b1}));
    // Palette words: {blue, green, red, index, unused byte}.
    plan.push_back(word_row(OP_PALETTE, {8'h00, 8'h00, 8'h00, 8'd0, 8'h00}));
    plan.push_back(word_row(OP_PALETTE, {8'h80, 8'h80, 8'h80, 8'd1, 8'h00}));
    plan.push_back(word_row(OP_PALETTE, {8'h40, 8'h40, 8'h40, 8'd2, 8'h00}));
    plan.push_back(word_row(OP_PALETTE, {8'hff, 8'hff, 8'hff, 8'd3, 8'hff}));
    plan.push_back(word_row(OP_PALETTE, {8'hff, 8'h00, 8'hff, 8'd255, 8'hff}));
    plan.push_back(cfg_row(FMT_2BIT, 1'b0, 12'd4, 12'd2));
    plan.push_back(word_row(OP_IMAGE, 40'he4, 1'b1, {8'he4, 1'b1, 1'b0}));
    plan.push_back(word_row(OP_IMAGE, 40'h1b, 1'b1, {8'h1b, 1'b1, 1'b1}));
    // Two-bit indexes go through the palette, not through a plain shift.
    plan.push_back(cfg_row(FMT_2BIT, 1'b1, 12'd4, 12'd1));
    plan.push_back(word_row(OP_IMAGE, 40'he4, 1'b1, {8'hd8, 1'b1, 1'b1}));
    // The row ends inside a source byte and the partial byte is left-aligned.
    plan.push_back(cfg_row(FMT_4BIT, 1'b0, 12'd3, 12'd1));
    plan.push_back(word_row(OP_IMAGE, 40'hf0));
    plan.push_back(word_row(OP_IMAGE, 40'h8c, 1'b1, {8'hc8, 1'b1, 1'b1}));
    // Palette use is ignored for RGB formats; blue is masked in RGB565.
    plan.push_back(cfg_row(FMT_RGB565, 1'b1, 12'd1, 12'd1));
    plan.push_back(word_row(OP_IMAGE, 40'hff));
    plan.push_back(word_row(OP_IMAGE, 40'hff, 1'b1, {8'hc0, 1'b1, 1'b1}));
    plan.push_back(word_row(OP_IMAGE, 40'h1f));
    plan.push_back(word_row(OP_IMAGE, 40'h07));
    plan.push_back(cfg_row(FMT_RGB24, 1'b0, 12'd2, 12'd1));
    plan.push_back(word_row(OP_IMAGE, 40'h10));
    plan.push_back(word_row(OP_IMAGE, 40'h20));
    plan.push_back(word_row(OP_IMAGE, 40'h30));
    plan.push_back(word_row(OP_IMAGE, 40'hff));
    plan.push_back(word_row(OP_IMAGE, 40'hff));
    plan.push_back(word_row(OP_IMAGE, 40'hff, 1'b1, {8'h30, 1'b1, 1'b1}));
    // Alpha byte is dropped.
    plan.push_back(cfg_row(FMT_RGBA32, 1'b0, 12'd1, 12'd1));
    plan.push_back(word_row(OP_IMAGE, 40'hff));
    plan.push_back(word_row(OP_IMAGE, 40'hff));
    plan.push_back(word_row(OP_IMAGE, 40'hff));
    plan.push_back(word_row(OP_IMAGE, 40'h00, 1'b1, {8'hc0, 1'b1, 1'b1}));
    // An unused format code acts as 8-bit; zero sizes act as one.
    plan.push_back(cfg_row(pixel_fmt_t'(3'd7), 1'b0, 12'd0, 12'd0));
    plan.push_back(word_row(OP_IMAGE, 40'h80, 1'b1, {8'h80, 1'b1, 1'b1}));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) load_settings(plan[i].fmt, plan[i].pal, plan[i].w, plan[i].h);
      else send_word(plan[i].op, plan[i].word, plan[i].typed, plan[i].want);
    end

    // Fill the whole palette so that every later lookup hits a written entry.
    for (int i = 0; i < 256; i++) begin
      rnd = $urandom;
      send_word(OP_PALETTE, {rnd[23:0], 8'(i), rnd[31:24]});
    end

    sent = 0;
    phase_no = 0;
    while (sent < 400) begin
      no_gaps = (phase_no >= 6 && phase_no < 12);
      if (phase_no == 0) begin
        // One result per word while the result side holds off for a long time.
        load_settings(FMT_8BIT, 1'b0, 12'd1, 12'd3);
        hold_req = 1'b1;
        span = 60;
      end else begin
        load_settings(pixel_fmt_t'($urandom_range(7)), 1'($urandom_range(1)),
                      pick_size(12), pick_size(4));
        span = $urandom_range(40, 4);
      end
      repeat (span) begin
        rnd = $urandom;
        if (phase_no != 0 && $urandom_range(99) < 8)
          send_word(OP_PALETTE, {rnd[23:0], 8'($urandom_range(255)), rnd[31:24]});
        else
          send_word(OP_IMAGE, {rnd, 8'($urandom_range(255))});
      end
      sent += span;
      phase_no++;
    end
    no_gaps = 1'b0;

    settle();
    repeat (16) @(posedge clk);
    if (errors == 0)
      $display("pixel_to_gray2_packer_unit regression: pass");
    else
      $display("pixel_to_gray2_packer_unit regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/p2g2_pkg.sv
rtl/pixel_to_gray2_packer_unit.sv
rtl/p2g2_checker.sv
test/pixel_to_gray2_packer_unit_tb.sv
